// ===== rtl/rtc_pkg.sv =====
// Package for the real-time clock block: operation codes, register indexes,
// status bit positions and reset constants. No dependencies.
`default_nettype none

package rtc_pkg;

  // Operation carried by each input word.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_e;

  // Register indexes of the bus side.
  typedef enum logic [1:0] {
    REG_COUNT  = 2'd0,
    REG_ALARM  = 2'd1,
    REG_STATUS = 2'd2
  } reg_e;

  // Status register bit positions.
  localparam int unsigned StAl  = 0;
  localparam int unsigned StHz  = 1;
  localparam int unsigned StAle = 2;
  localparam int unsigned StHze = 3;
  localparam int unsigned StatusWidth = 4;

  localparam int unsigned DataWidth    = 32;
  localparam int unsigned DividerWidth = 16;

  // Divider after reset: one second of a 32.768 kHz input clock.
  localparam logic [DividerWidth-1:0] DividerReset = 16'd32767;

endpackage

`default_nettype wire

// ===== rtl/rtc_seconds_counter_with_alarm_top.sv =====
// An accepted word is held in the input register; its result word is shown from the result
// register. Throughput: one word per cycle while the result register is free or taken;
// the state update is a single pass of adder and comparator.
// The input register empties into the result register whenever that one is free or taken.
// Reset clears the count, alarm, prescaler and status to zero and loads the divider 32767.
// Top level of the real-time clock: seconds counter, prescaler, alarm and status flags.
// Depends on rtc_pkg.
`default_nettype none

module rtc_seconds_counter_with_alarm_top
  import rtc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH    = 32,
  parameter int unsigned PRESCALE_WIDTH = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // Configuration write channel (divider).
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [DividerWidth-1:0] cfg_data_i,
  // Input word channel.
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [1:0]              operation_i,
  input  wire logic [1:0]              reg_index_i,
  input  wire logic [DataWidth-1:0]    write_data_i,
  // Result word channel.
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [DataWidth-1:0]         read_data_o,
  output logic                         alarm_irq_o,
  output logic                         second_irq_o
);

  localparam int unsigned CmpWidth =
    (PRESCALE_WIDTH > DividerWidth) ? PRESCALE_WIDTH : DividerWidth;

  // Architectural state.
  logic [DividerWidth-1:0]   divider_q;
  logic [COUNT_WIDTH-1:0]    count_q, count_d;
  logic [COUNT_WIDTH-1:0]    alarm_q, alarm_d;
  logic [PRESCALE_WIDTH-1:0] presc_q, presc_d;
  logic [StatusWidth-1:0]    status_q, status_d;

  // Input register.
  logic                 s1_valid_q;
  logic [1:0]           s1_op_q;
  logic [1:0]           s1_idx_q;
  logic [DataWidth-1:0] s1_data_q;

  // Result register payload.
  logic [DataWidth-1:0] read_data_q, read_data_d;
  logic                 out_valid_q;

  logic s1_move;
  logic s1_load;
  logic rollover;
  logic [COUNT_WIDTH-1:0] count_inc;

  // Always writable; writes must come while the block is idle, which it does not enforce.
  assign cfg_ready_o = 1'b1;

  // The input register moves on whenever the result register is empty or being taken.
  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign s1_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divider_q <= DividerReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      divider_q <= cfg_data_i;
    end
  end

  // Input register: valid bit under reset, payload without.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load || s1_move) begin
      s1_valid_q <= s1_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_op_q   <= operation_i;
      s1_idx_q  <= reg_index_i;
      s1_data_q <= write_data_i;
    end
  end

  // The second completes when the prescaler reaches the divider or its own maximum.
  assign rollover  = (CmpWidth'(presc_q) >= CmpWidth'(divider_q)) || (presc_q == '1);
  assign count_inc = count_q + COUNT_WIDTH'(1);

  // Single-pass state update and read data for the word in the input register.
  always_comb begin
    count_d     = count_q;
    alarm_d     = alarm_q;
    presc_d     = presc_q;
    status_d    = status_q;
    read_data_d = '0;
    unique case (s1_op_q)
      OP_TICK: begin
        if (rollover) begin
          presc_d        = '0;
          count_d        = count_inc;
          status_d[StHz] = 1'b1;
          if (count_inc == alarm_q) begin
            status_d[StAl] = 1'b1;
          end
        end else begin
          presc_d = presc_q + PRESCALE_WIDTH'(1);
        end
      end
      OP_READ: begin
        unique case (s1_idx_q)
          REG_COUNT:  read_data_d = DataWidth'(count_q);
          REG_ALARM:  read_data_d = DataWidth'(alarm_q);
          REG_STATUS: read_data_d = DataWidth'(status_q);
          default:    read_data_d = '0;
        endcase
      end
      OP_WRITE: begin
        unique case (s1_idx_q)
          REG_COUNT: count_d = COUNT_WIDTH'(s1_data_q);
          REG_ALARM: alarm_d = COUNT_WIDTH'(s1_data_q);
          REG_STATUS: begin
            // Flags are write-one-to-clear; enables are written directly.
            status_d[StAl]  = status_q[StAl] & ~s1_data_q[StAl];
            status_d[StHz]  = status_q[StHz] & ~s1_data_q[StHz];
            status_d[StAle] = s1_data_q[StAle];
            status_d[StHze] = s1_data_q[StHze];
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // State registers advance once per word leaving the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      alarm_q  <= '0;
      presc_q  <= '0;
      status_q <= '0;
    end else if (s1_move) begin
      count_q  <= count_d;
      alarm_q  <= alarm_d;
      presc_q  <= presc_d;
      status_q <= status_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move || !out_stall_i) begin
      out_valid_q <= s1_move;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      read_data_q  <= read_data_d;
      alarm_irq_o  <= status_d[StAl] & status_d[StAle];
      second_irq_o <= status_d[StHz] & status_d[StHze];
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

  // The input side is only held back while a word waits in the input register.
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty input register");

  // Interrupt outputs of a fresh result agree with the status that word left.
  a_irq_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> (alarm_irq_o == (status_q[StAl] & status_q[StAle])) &&
                (second_irq_o == (status_q[StHz] & status_q[StHze])))
    else $error("interrupt outputs disagree with status");

  // The 1 Hz flag is only ever set by a tick.
  a_hz_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(status_q[StHz]) |-> $past(s1_move && (s1_op_q == OP_TICK)))
    else $error("1 Hz flag set without a tick");

  // A completed second advances the count by exactly one.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && (s1_op_q == OP_TICK) && rollover) |=>
      (count_q == $past(count_inc)) && (presc_q == '0))
    else $error("count did not advance on a completed second");

endmodule

`default_nettype wire

// ===== dv/rtc_seconds_counter_with_alarm_top_tb.sv =====
// Testbench for the real-time clock top level: drives tick, read and write words under random
// stalls and checks every result word against a cycle-free prediction of the clock state.
// Depends on rtc_pkg and rtc_seconds_counter_with_alarm_top.

module rtc_seconds_counter_with_alarm_top_tb;
  import rtc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Codes that the package leaves unnamed but the bus can still carry.
  localparam logic [1:0] OpUnused  = 2'd3;
  localparam logic [1:0] RegUnused = 2'd3;

  // Cycles without a transfer on any channel before the run is abandoned.
  localparam int unsigned StuckLimit = 2000;
  // Length of the deliberate result hold-off and the result it starts after.
  localparam int unsigned HoldOffCycles = 150;
  localparam int unsigned HoldOffAfter  = 400;

  typedef struct packed {
    logic [DataWidth-1:0] read_data;
    logic                 alarm_irq;
    logic                 second_irq;
  } rtc_result_t;

  // Tracks the clock state word by word and holds the result words still owed.
  class rtc_tracker;
    logic [DividerWidth-1:0] divider;
    logic [DataWidth-1:0]    seconds;
    logic [DataWidth-1:0]    alarm;
    logic [15:0]             prescale;
    logic [StatusWidth-1:0]  status;
    rtc_result_t             expected_words[$];
    int unsigned             errors;

    function new();
      divider  = DividerReset;
      seconds  = '0;
      alarm    = '0;
      prescale = '0;
      status   = '0;
      errors   = 0;
    endfunction

    function void set_divider(logic [DividerWidth-1:0] value);
      divider = value;
    endfunction

    // Applies one accepted input word and queues the result word it must produce.
    function void note_word(logic [1:0] op, logic [1:0] idx, logic [DataWidth-1:0] data);
      rtc_result_t            res;
      logic [StatusWidth-1:0] next_status;
      res = '0;
      case (op)
        OP_TICK: begin
          // The second completes once the prescaler reaches the divider or its own ceiling.
          if (prescale >= divider || prescale == 16'hFFFF) begin
            prescale = '0;
            seconds = seconds + 1'b1;
            status[StHz] = 1'b1;
            if (seconds == alarm) status[StAl] = 1'b1;
          end else begin
            prescale = prescale + 1'b1;
          end
        end
        OP_READ: begin
          case (idx)
            REG_COUNT:  res.read_data = seconds;
            REG_ALARM:  res.read_data = alarm;
            REG_STATUS: res.read_data = {{(DataWidth-StatusWidth){1'b0}}, status};
            default:    res.read_data = '0;
          endcase
        end
        OP_WRITE: begin
          case (idx)
            REG_COUNT: seconds = data;
            REG_ALARM: alarm = data;
            REG_STATUS: begin
              // Flags clear on a one; enables take the written value.
              next_status = '0;
              next_status[StAl]  = status[StAl] & ~data[StAl];
              next_status[StHz]  = status[StHz] & ~data[StHz];
              next_status[StAle] = data[StAle];
              next_status[StHze] = data[StHze];
              status = next_status;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      res.alarm_irq  = status[StAl] & status[StAle];
      res.second_irq = status[StHz] & status[StHze];
      expected_words.push_back(res);
    endfunction

    // Compares a result word with the oldest one owed.
    function void check_word(rtc_result_t got);
      rtc_result_t want;
      if (expected_words.size() == 0) begin
        $error("result word with none expected: read_data %0h", got.read_data);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
        errors++;
      end
      if (got.alarm_irq !== want.alarm_irq) begin
        $error("alarm_irq: expected %0b, got %0b", want.alarm_irq, got.alarm_irq);
        errors++;
      end
      if (got.second_irq !== want.second_irq) begin
        $error("second_irq: expected %0b, got %0b", want.second_irq, got.second_irq);
        errors++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic [DividerWidth-1:0] cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic [1:0]              operation = '0;
  logic [1:0]              reg_index = '0;
  logic [DataWidth-1:0]    write_data = '0;
  logic                    out_stall = 1'b0;
  wire                     cfg_ready_o;
  wire                     in_stall_o;
  wire                     out_valid_o;
  wire [DataWidth-1:0]     read_data_o;
  wire                     alarm_irq_o;
  wire                     second_irq_o;

  rtc_tracker  tracker;
  int unsigned send_run = 0;
  int unsigned recv_run = 0;

  rtc_seconds_counter_with_alarm_top uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation),
    .reg_index_i  (reg_index),
    .write_data_i (write_data),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .read_data_o  (read_data_o),
    .alarm_irq_o  (alarm_irq_o),
    .second_irq_o (second_irq_o)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Idle cycles before the next word: mostly random, with occasional back-to-back runs.
  function automatic int unsigned draw_gap(inout int unsigned run_left);
    if (run_left != 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      run_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  // Offers one input word and waits until the block takes it.
  task automatic send_word(input logic [1:0] op, input logic [1:0] idx,
                           input logic [DataWidth-1:0] data);
    int unsigned gap;
    gap = draw_gap(send_run);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    reg_index  <= idx;
    write_data <= data;
    do @(posedge clk); while (in_stall_o !== 1'b0);
    tracker.note_word(op, idx, data);
  endtask

  // Random word, biased towards sequences that reach seconds roll-over and alarm matches.
  task automatic send_random();
    logic [1:0]           op;
    logic [1:0]           idx;
    logic [DataWidth-1:0] data;
    int unsigned          pick;
    pick = $urandom_range(0, 99);
    idx  = 2'($urandom_range(0, 3));
    data = $urandom();
    if (pick < 55) begin
      op = OP_TICK;
    end else if (pick < 70) begin
      op = OP_READ;
    end else if (pick < 95) begin
      op = OP_WRITE;
      idx = ($urandom_range(0, 9) == 0) ? RegUnused : 2'($urandom_range(0, 2));
      case (idx)
        REG_COUNT: begin
          if ($urandom_range(0, 7) == 0) data = 32'hFFFF_FFFF - 32'($urandom_range(0, 2));
          else if ($urandom_range(0, 1) != 0) data = tracker.alarm - 32'($urandom_range(0, 2));
        end
        REG_ALARM: begin
          if ($urandom_range(0, 3) != 0) data = tracker.seconds + 32'($urandom_range(0, 3));
        end
        default: ;
      endcase
    end else begin
      op = OpUnused;
    end
    send_word(op, idx, data);
  endtask

  // Waits until every owed result word has come back and the pipeline is empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_divider(input logic [DividerWidth-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready_o !== 1'b1);
    cfg_valid <= 1'b0;
    tracker.set_divider(value);
  endtask

  // Result side: random stalls, one long hold-off to back the block up.
  initial begin : result_sink
    int unsigned gap;
    int unsigned taken;
    rtc_result_t got;
    taken = 0;
    forever begin
      gap = draw_gap(recv_run);
      if (taken == HoldOffAfter) gap = HoldOffCycles;
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid_o !== 1'b1);
      got.read_data  = read_data_o;
      got.alarm_irq  = alarm_irq_o;
      got.second_irq = second_irq_o;
      tracker.check_word(got);
      taken++;
    end
  end

  // Ends the run if no word moves on any channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StuckLimit) begin
      @(posedge clk);
      if ((in_valid && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall) ||
          (cfg_valid && cfg_ready_o === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("rtc_seconds_counter_with_alarm_top_tb: errors");
    $finish;
  end

  initial begin : stimulus
    logic [DividerWidth-1:0] phase_div[8];
    int unsigned             words;
    tracker = new();
    phase_div = '{16'd0, 16'hFFFF, 16'd1, 16'd3, 16'd2, 16'd7, 16'd0, 16'd5};
    phase_div[6] = 16'($urandom_range(0, 20));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // State straight after reset, with the reset divider still in place.
    send_word(OP_READ, REG_COUNT, 32'h0);
    send_word(OP_READ, REG_ALARM, 32'h0);
    send_word(OP_READ, REG_STATUS, 32'h0);
    send_word(OP_READ, RegUnused, 32'h0);
    send_word(OP_TICK, REG_COUNT, 32'h0);
    drain();
    write_divider(16'd1);

    // Count wrap into an alarm match, flag clearing and enables.
    send_word(OP_WRITE, REG_STATUS, 32'hFFFF_FFFF);
    send_word(OP_WRITE, REG_COUNT, 32'hFFFF_FFFE);
    send_word(OP_WRITE, REG_ALARM, 32'h0000_0000);
    send_word(OP_TICK, REG_COUNT, 32'h0);
    send_word(OP_TICK, REG_COUNT, 32'h0);
    send_word(OP_TICK, REG_COUNT, 32'h0);
    send_word(OP_READ, REG_COUNT, 32'h0);
    send_word(OP_READ, REG_STATUS, 32'h0);
    send_word(OP_WRITE, REG_STATUS, 32'h0000_000D);
    send_word(OP_READ, REG_STATUS, 32'h0);
    send_word(OP_WRITE, REG_STATUS, 32'h0000_0002);
    // Writing the count onto the alarm value must not raise the alarm.
    send_word(OP_WRITE, REG_ALARM, 32'h0000_0005);
    send_word(OP_WRITE, REG_COUNT, 32'h0000_0005);
    send_word(OP_READ, REG_STATUS, 32'h0);
    // Unused register and operation codes change nothing.
    send_word(OP_WRITE, RegUnused, 32'hFFFF_FFFF);
    send_word(OpUnused, RegUnused, 32'hFFFF_FFFF);
    send_word(OpUnused, REG_COUNT, 32'h0);
    send_word(OP_READ, RegUnused, 32'h0);
    send_word(OP_WRITE, REG_ALARM, 32'hFFFF_FFFF);
    send_word(OP_READ, REG_ALARM, 32'h0);
    send_word(OP_WRITE, REG_STATUS, 32'h0000_0004);
    send_word(OP_WRITE, REG_COUNT, 32'hFFFF_FFFE);
    send_word(OP_TICK, REG_STATUS, 32'h0);
    send_word(OP_TICK, REG_STATUS, 32'h0);
    send_word(OP_READ, REG_STATUS, 32'h0);
    drain();

    // Divider lowered below a prescaler already part-way through a second.
    write_divider(16'd40);
    repeat (30) send_word(OP_TICK, 2'($urandom_range(0, 3)), $urandom());
    drain();
    write_divider(16'd5);
    send_word(OP_TICK, REG_COUNT, 32'h0);
    send_word(OP_READ, REG_COUNT, 32'h0);
    drain();

    // Random phases over a spread of dividers, the extremes among them.
    foreach (phase_div[p]) begin
      write_divider(phase_div[p]);
      words = (phase_div[p] == 16'hFFFF) ? 60 : 200;
      repeat (words) send_random();
      drain();
    end

    if (tracker.errors == 0) begin
      $display("rtc_seconds_counter_with_alarm_top_tb: clean");
    end else begin
      $display("rtc_seconds_counter_with_alarm_top_tb: errors");
    end
    $finish;
  end

endmodule
